// ----- sv/ppls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phong point-light shader package
// Shared widths, register codes, carried payload types and the saturating
// Q2.14 multiply used throughout the shading pipeline.
// ----------------------------------------------------------------------------
package ppls_pkg;

   localparam int SHININESS_BITS_DEF = 8;
   localparam int SHIN_W = 8;     // width of the shininess field
   localparam int POS_W = 32;     // Q16.16 position
   localparam int VEC_W = 16;     // Q2.14 vector component
   localparam int COL_W = 16;     // Q2.14 colour / coefficient
   localparam int DIF_W = POS_W + 1;
   localparam int NRM_W = 30;     // normalised magnitude, top bit at 29
   localparam int SQ_W = 62;      // sum of three squares
   localparam int LEN_W = SQ_W / 2;
   localparam int FRAC_W = 14;
   localparam int QUO_W = FRAC_W + 1;
   localparam int REQ_W = 296;
   localparam int RSP_W = 48;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [31:0] ONE_Q14 = 32'd16384;
   localparam logic [COL_W-1:0] INT_RESET = 16'd16384;

   localparam logic [CSR_AW-1:0] REG_LIGHT_POS_X = 3'd0;
   localparam logic [CSR_AW-1:0] REG_LIGHT_POS_Y = 3'd1;
   localparam logic [CSR_AW-1:0] REG_LIGHT_POS_Z = 3'd2;
   localparam logic [CSR_AW-1:0] REG_LIGHT_RED = 3'd3;
   localparam logic [CSR_AW-1:0] REG_LIGHT_GREEN = 3'd4;
   localparam logic [CSR_AW-1:0] REG_LIGHT_BLUE = 3'd5;

   // Per-item fields that ride along the whole pipeline.
   typedef struct packed {
      logic [2:0]             neg;
      logic [2:0][VEC_W-1:0]  eye;
      logic [2:0][VEC_W-1:0]  normal;
      logic [2:0][COL_W-1:0]  mat;      // index 0 red, 1 green, 2 blue
      logic [COL_W-1:0]       ka;
      logic [COL_W-1:0]       kd;
      logic [COL_W-1:0]       ks;
      logic [SHIN_W-1:0]      shin;
   } side_type;

   typedef struct packed {
      side_type               side;
      logic [2:0][NRM_W-1:0]  mag;
   } sq_pay_type;

   typedef struct packed {
      side_type side;
      logic     zero;
   } div_pay_type;

   typedef struct packed {
      side_type    side;
      logic        lit;
      logic [16:0] ln14;
   } shade_type;

   // Q2.14 product, floor, saturated to 32 bits.
   function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = {32'd0, a} * {32'd0, b};
      if (p[63:46] != 18'd0) begin
         return 32'hFFFF_FFFF;
      end
      return p[45:14];
   endfunction

endpackage

// ----- sv/phong_point_light_shader_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phong point-light shader
// Fixed-point Phong shading of one surface hit against one point light.
// ----------------------------------------------------------------------------
// The shader takes one request per clock, unless the output is stalled, and
// returns one shaded colour per request, in order. The pipeline depth comes
// from the pipelined square root of the light distance (one root bit per
// stage), the fractional divider that normalises the light vector (one
// quotient bit per stage) and the power chain, which takes one
// square-and-multiply step per exponent bit. The whole pipeline advances
// together and simply holds while a finished result waits on rsp_tready, so
// nothing is dropped or repeated. The light position and intensity registers
// must only be written while no request is in flight.
// ----------------------------------------------------------------------------
module phong_point_light_shader_top #(
   parameter int SHININESS_BITS = ppls_pkg::SHININESS_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request: point_x, point_y, point_z (Q16.16), eye_x/y/z, normal_x/y/z
   // (Q2.14), material_rgb (48), material_coeffs (48), shininess (8).
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ppls_pkg::REQ_W-1:0]    req_tdata,
   // Result: out_red, out_green, out_blue (Q2.14, saturated).
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ppls_pkg::RSP_W-1:0]    rsp_tdata,
   // Result flag: lit.
   output logic                          rsp_tuser,
   input  logic                          csr_we,
   input  logic [ppls_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [ppls_pkg::CSR_DW-1:0]   csr_wdata
);
   localparam int SB = SHININESS_BITS;
   localparam int SQ_PAY_W = $bits(ppls_pkg::sq_pay_type);
   localparam int DIV_PAY_W = $bits(ppls_pkg::div_pay_type);

   // Configuration registers.
   logic [ppls_pkg::POS_W-1:0] light_pos_ff [3];
   logic [ppls_pkg::COL_W-1:0] light_int_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            light_pos_ff[i] <= '0;
            light_int_ff[i] <= ppls_pkg::INT_RESET;
         end
      end else if (csr_we) begin
         case (csr_addr)
            ppls_pkg::REG_LIGHT_POS_X: light_pos_ff[0] <= csr_wdata;
            ppls_pkg::REG_LIGHT_POS_Y: light_pos_ff[1] <= csr_wdata;
            ppls_pkg::REG_LIGHT_POS_Z: light_pos_ff[2] <= csr_wdata;
            ppls_pkg::REG_LIGHT_RED:   light_int_ff[0] <= csr_wdata[15:0];
            ppls_pkg::REG_LIGHT_GREEN: light_int_ff[1] <= csr_wdata[15:0];
            ppls_pkg::REG_LIGHT_BLUE:  light_int_ff[2] <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves as one; it holds only while the output
   // register carries a result that the consumer has not yet taken.
   logic en;
   logic v15_ff;
   assign en = !v15_ff || rsp_tready;
   assign req_tready = en;

   // Unpack the request.
   ppls_pkg::side_type req_side;
   logic [ppls_pkg::POS_W-1:0] req_point [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         req_point[i] = req_tdata[32*i +: 32];
         req_side.eye[i] = req_tdata[96 + 16*i +: 16];
         req_side.normal[i] = req_tdata[144 + 16*i +: 16];
         req_side.mat[i] = req_tdata[192 + 32 - 16*i +: 16];
      end
      req_side.ka = req_tdata[240 + 32 +: 16];
      req_side.kd = req_tdata[240 + 16 +: 16];
      req_side.ks = req_tdata[240 +: 16];
      req_side.shin = req_tdata[288 +: 8];
      req_side.neg = '0;
   end

   // Stage 1: light minus point, split into sign and magnitude.
   logic v1_ff;
   ppls_pkg::side_type side1_ff;
   logic [ppls_pkg::DIF_W-1:0] mag1_ff [3];
   ppls_pkg::side_type side1_in;
   logic [ppls_pkg::DIF_W-1:0] mag1_in [3];
   logic [ppls_pkg::DIF_W-1:0] d1;

   always_comb begin
      side1_in = req_side;
      for (int i = 0; i < 3; i++) begin
         d1 = {light_pos_ff[i][31], light_pos_ff[i]} - {req_point[i][31], req_point[i]};
         side1_in.neg[i] = d1[ppls_pkg::DIF_W-1];
         mag1_in[i] = d1[ppls_pkg::DIF_W-1] ? (~d1 + 1'b1) : d1;
      end
   end

   // Stage 2: position of the leading one over all three magnitudes.
   logic v2_ff;
   ppls_pkg::side_type side2_ff;
   logic [ppls_pkg::DIF_W-1:0] mag2_ff [3];
   logic [5:0] msb2_ff;
   logic [5:0] msb2_in;
   logic [ppls_pkg::DIF_W-1:0] or2;

   always_comb begin
      or2 = mag1_ff[0] | mag1_ff[1] | mag1_ff[2];
      msb2_in = '0;
      for (int b = 0; b < ppls_pkg::DIF_W; b++) begin
         if (or2[b]) begin
            msb2_in = 6'(b);
         end
      end
   end

   // Stage 3: common shift so that the largest magnitude lies in [2^29, 2^30).
   logic v3_ff;
   ppls_pkg::side_type side3_ff;
   logic [ppls_pkg::NRM_W-1:0] mag3_ff [3];
   logic [ppls_pkg::NRM_W-1:0] mag3_in [3];
   logic [ppls_pkg::DIF_W-1:0] t3;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (msb2_ff >= 6'd30) begin
            t3 = mag2_ff[i] >> (msb2_ff - 6'd29);
         end else begin
            t3 = mag2_ff[i] << (6'd29 - msb2_ff);
         end
         mag3_in[i] = t3[ppls_pkg::NRM_W-1:0];
      end
   end

   // Stage 4: squares. Stage 5: their sum.
   logic v4_ff;
   ppls_pkg::side_type side4_ff;
   logic [ppls_pkg::NRM_W-1:0] mag4_ff [3];
   logic [2*ppls_pkg::NRM_W-1:0] sq4_ff [3];
   logic v5_ff;
   ppls_pkg::sq_pay_type pay5_ff;
   logic [ppls_pkg::SQ_W-1:0] sum5_ff;

   // Square root and division.
   logic sq_v;
   logic [ppls_pkg::LEN_W-1:0] sq_len;
   logic [SQ_PAY_W-1:0] sq_pay_bits;
   ppls_pkg::sq_pay_type sq_pay;
   ppls_pkg::div_pay_type dv_pay_in;
   logic dv_v;
   logic [2:0][ppls_pkg::QUO_W-1:0] dv_quo;
   logic [DIV_PAY_W-1:0] dv_pay_bits;
   ppls_pkg::div_pay_type dv_pay;

   ppls_isqrt #(
      .IN_W  (ppls_pkg::SQ_W),
      .PAY_W (SQ_PAY_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_x      (sum5_ff),
      .in_pay    (pay5_ff),
      .out_valid (sq_v),
      .out_root  (sq_len),
      .out_pay   (sq_pay_bits)
   );

   assign sq_pay = sq_pay_bits;
   assign dv_pay_in.side = sq_pay.side;
   assign dv_pay_in.zero = (sq_len == '0);

   ppls_div #(
      .LANES (3),
      .MAG_W (ppls_pkg::NRM_W),
      .DEN_W (ppls_pkg::LEN_W),
      .PAY_W (DIV_PAY_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_v),
      .in_mag    (sq_pay.mag),
      .in_den    (sq_len),
      .in_pay    (dv_pay_in),
      .out_valid (dv_v),
      .out_quo   (dv_quo),
      .out_pay   (dv_pay_bits)
   );

   assign dv_pay = dv_pay_bits;

   // Stage 6: signed unit light vector. A light sitting on the hit point
   // gives a zero vector.
   logic v6_ff;
   ppls_pkg::side_type side6_ff;
   logic [15:0] l6_ff [3];
   logic [15:0] l6_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_pay.zero) begin
            l6_in[i] = '0;
         end else if (dv_pay.side.neg[i]) begin
            l6_in[i] = ~{1'b0, dv_quo[i]} + 1'b1;
         end else begin
            l6_in[i] = {1'b0, dv_quo[i]};
         end
      end
   end

   // Stage 7: light dot normal products. Stage 8: their sum.
   logic v7_ff;
   ppls_pkg::side_type side7_ff;
   logic [15:0] l7_ff [3];
   logic [31:0] lnp7_ff [3];
   logic v8_ff;
   ppls_pkg::shade_type sh8_ff;
   logic [15:0] l8_ff [3];
   ppls_pkg::shade_type sh8_in;
   logic [33:0] ln8;

   always_comb begin
      ln8 = {{2{lnp7_ff[0][31]}}, lnp7_ff[0]} + {{2{lnp7_ff[1][31]}}, lnp7_ff[1]}
          + {{2{lnp7_ff[2][31]}}, lnp7_ff[2]};
      sh8_in.side = side7_ff;
      sh8_in.lit = !ln8[33];
      sh8_in.ln14 = ln8[33] ? 17'd0 : ln8[30:14];
   end

   // Stage 9: 2 * ln14 * n. Stage 10: reflected vector r.
   logic v9_ff;
   ppls_pkg::shade_type sh9_ff;
   logic [15:0] l9_ff [3];
   logic [34:0] p9_ff [3];
   logic v10_ff;
   ppls_pkg::shade_type sh10_ff;
   logic [21:0] r10_ff [3];
   logic [21:0] r10_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r10_in[i] = {p9_ff[i][34], p9_ff[i][34:14]} - {{6{l9_ff[i][15]}}, l9_ff[i]};
      end
   end

   // Stage 11: r dot eye products. Stage 12: sum and power operands.
   logic v11_ff;
   ppls_pkg::shade_type sh11_ff;
   logic [37:0] re11_ff [3];
   logic v12_ff;
   ppls_pkg::shade_type sh12_ff;
   logic [31:0] acc12_ff;
   logic [31:0] base12_ff;
   logic [39:0] re12;
   logic pw_en12;

   always_comb begin
      re12 = {{2{re11_ff[0][37]}}, re11_ff[0]} + {{2{re11_ff[1][37]}}, re11_ff[1]}
           + {{2{re11_ff[2][37]}}, re11_ff[2]};
      pw_en12 = sh11_ff.lit && !re12[39];
   end

   // Power chain: one square-and-multiply step per exponent bit. When the
   // reflection points away from the eye or the hit is not lit, the accumulator starts at zero.
   logic                pw_v_ff    [SB];
   ppls_pkg::shade_type pw_sh_ff   [SB];
   logic [31:0]         pw_acc_ff  [SB];
   logic [31:0]         pw_base_ff [SB];

   genvar j;
   generate
      for (j = 0; j < SB; j++) begin : g_pow
         logic                v_src;
         ppls_pkg::shade_type sh_src;
         logic [31:0]         acc_src;
         logic [31:0]         base_src;
         logic                bit_sel;

         if (j == 0) begin : g_first
            assign v_src = v12_ff;
            assign sh_src = sh12_ff;
            assign acc_src = acc12_ff;
            assign base_src = base12_ff;
         end else begin : g_next
            assign v_src = pw_v_ff[j-1];
            assign sh_src = pw_sh_ff[j-1];
            assign acc_src = pw_acc_ff[j-1];
            assign base_src = pw_base_ff[j-1];
         end

         if (j < ppls_pkg::SHIN_W) begin : g_bit
            assign bit_sel = sh_src.side.shin[j];
         end else begin : g_nobit
            assign bit_sel = 1'b0;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               pw_v_ff[j] <= 1'b0;
            end else if (en) begin
               pw_v_ff[j] <= v_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               pw_sh_ff[j] <= sh_src;
               pw_acc_ff[j] <= bit_sel ? ppls_pkg::qmul(acc_src, base_src) : acc_src;
               pw_base_ff[j] <= ppls_pkg::qmul(base_src, base_src);
            end
         end
      end
   endgenerate

   // Stage 13: diffuse and specular factors, effective colour.
   logic v13_ff;
   ppls_pkg::shade_type sh13_ff;
   logic [31:0] dr13_ff;
   logic [31:0] sr13_ff;
   logic [31:0] eff13_ff [3];
   ppls_pkg::shade_type sh_pw;
   assign sh_pw = pw_sh_ff[SB-1];

   // Stage 14: ambient, diffuse and specular terms per channel.
   logic v14_ff;
   logic lit14_ff;
   logic [31:0] amb14_ff [3];
   logic [31:0] dif14_ff [3];
   logic [31:0] spc14_ff [3];

   // Stage 15: channel sums, saturated; this is the output register.
   logic [ppls_pkg::COL_W-1:0] out15_ff [3];
   logic lit15_ff;
   logic [ppls_pkg::COL_W-1:0] out15_in [3];
   logic [33:0] tot15;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tot15 = {2'b00, amb14_ff[i]};
         if (lit14_ff) begin
            tot15 = tot15 + {2'b00, dif14_ff[i]} + {2'b00, spc14_ff[i]};
         end
         out15_in[i] = (tot15 > 34'hFFFF) ? 16'hFFFF : tot15[15:0];
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
         v14_ff <= 1'b0;
         v15_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= dv_v;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
         v12_ff <= v11_ff;
         v13_ff <= pw_v_ff[SB-1];
         v14_ff <= v13_ff;
         v15_ff <= v14_ff;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side1_in;
         side2_ff <= side1_ff;
         msb2_ff <= msb2_in;
         side3_ff <= side2_ff;
         side4_ff <= side3_ff;
         pay5_ff.side <= side4_ff;
         sum5_ff <= {2'b00, sq4_ff[0]} + {2'b00, sq4_ff[1]} + {2'b00, sq4_ff[2]};
         side6_ff <= dv_pay.side;
         side7_ff <= side6_ff;
         sh8_ff <= sh8_in;
         sh9_ff <= sh8_ff;
         sh10_ff <= sh9_ff;
         sh11_ff <= sh10_ff;
         sh12_ff <= sh11_ff;
         acc12_ff <= pw_en12 ? ppls_pkg::ONE_Q14 : 32'd0;
         base12_ff <= pw_en12 ? {6'd0, re12[39:14]} : 32'd0;
         sh13_ff <= sh_pw;
         dr13_ff <= ppls_pkg::qmul({16'd0, sh_pw.side.kd}, {15'd0, sh_pw.ln14});
         sr13_ff <= ppls_pkg::qmul({16'd0, sh_pw.side.ks}, pw_acc_ff[SB-1]);
         lit14_ff <= sh13_ff.lit;
         lit15_ff <= lit14_ff;
         for (int i = 0; i < 3; i++) begin
            mag1_ff[i] <= mag1_in[i];
            mag2_ff[i] <= mag1_ff[i];
            mag3_ff[i] <= mag3_in[i];
            mag4_ff[i] <= mag3_ff[i];
            sq4_ff[i] <= {30'd0, mag3_ff[i]} * {30'd0, mag3_ff[i]};
            pay5_ff.mag[i] <= mag4_ff[i];
            l6_ff[i] <= l6_in[i];
            l7_ff[i] <= l6_ff[i];
            lnp7_ff[i] <= $signed({{16{l6_ff[i][15]}}, l6_ff[i]})
                          * $signed({{16{side6_ff.normal[i][15]}}, side6_ff.normal[i]});
            l8_ff[i] <= l7_ff[i];
            l9_ff[i] <= l8_ff[i];
            p9_ff[i] <= $signed({17'd0, sh8_ff.ln14, 1'b0})
                        * $signed({{19{sh8_ff.side.normal[i][15]}}, sh8_ff.side.normal[i]});
            r10_ff[i] <= r10_in[i];
            re11_ff[i] <= $signed({{16{r10_ff[i][21]}}, r10_ff[i]})
                          * $signed({{22{sh10_ff.side.eye[i][15]}}, sh10_ff.side.eye[i]});
            eff13_ff[i] <= ppls_pkg::qmul({16'd0, sh_pw.side.mat[i]},
                                          {16'd0, light_int_ff[i]});
            amb14_ff[i] <= ppls_pkg::qmul(eff13_ff[i], {16'd0, sh13_ff.side.ka});
            dif14_ff[i] <= ppls_pkg::qmul(eff13_ff[i], dr13_ff);
            spc14_ff[i] <= ppls_pkg::qmul({16'd0, light_int_ff[i]}, sr13_ff);
            out15_ff[i] <= out15_in[i];
         end
      end
   end

   assign rsp_tvalid = v15_ff;
   assign rsp_tdata = {out15_ff[2], out15_ff[1], out15_ff[0]};
   assign rsp_tuser = lit15_ff;

endmodule

// ----- sv/ppls_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one root bit resolved per register stage, with a
// payload carried alongside.
// ----------------------------------------------------------------------------
module ppls_isqrt #(
   parameter int IN_W = ppls_pkg::SQ_W,
   parameter int PAY_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [IN_W-1:0]      in_x,
   input  logic [PAY_W-1:0]     in_pay,
   output logic                 out_valid,
   output logic [IN_W/2-1:0]    out_root,
   output logic [PAY_W-1:0]     out_pay
);
   localparam int ROOT_W = IN_W / 2;
   localparam int REM_W = ROOT_W + 2;

   logic              v_ff    [ROOT_W];
   logic [IN_W-1:0]   x_ff    [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [PAY_W-1:0]  pay_ff  [ROOT_W];

   genvar k;
   generate
      for (k = 0; k < ROOT_W; k++) begin : g_step
         logic              v_src;
         logic [IN_W-1:0]   x_src;
         logic [REM_W-1:0]  rem_src;
         logic [ROOT_W-1:0] root_src;
         logic [PAY_W-1:0]  pay_src;
         logic [REM_W-1:0]  rem_sh;
         logic [REM_W-1:0]  trial;
         logic [REM_W-1:0]  rem_in;
         logic [ROOT_W-1:0] root_in;
         logic              ge;

         if (k == 0) begin : g_first
            assign v_src = in_valid;
            assign x_src = in_x;
            assign rem_src = '0;
            assign root_src = '0;
            assign pay_src = in_pay;
         end else begin : g_next
            assign v_src = v_ff[k-1];
            assign x_src = x_ff[k-1];
            assign rem_src = rem_ff[k-1];
            assign root_src = root_ff[k-1];
            assign pay_src = pay_ff[k-1];
         end

         always_comb begin
            rem_sh = {rem_src[ROOT_W-1:0], x_src[IN_W-1 -: 2]};
            trial = {root_src, 2'b01};
            ge = (rem_sh >= trial);
            rem_in = ge ? (rem_sh - trial) : rem_sh;
            root_in = {root_src[ROOT_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en) begin
               v_ff[k] <= v_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[k] <= x_src << 2;
               rem_ff[k] <= rem_in;
               root_ff[k] <= root_in;
               pay_ff[k] <= pay_src;
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];
   assign out_pay = pay_ff[ROOT_W-1];

endmodule

// ----- sv/ppls_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined fractional divider
// Restoring division of (mag << FRAC_W) by a shared divisor for several
// lanes; one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ppls_div #(
   parameter int LANES = 3,
   parameter int MAG_W = ppls_pkg::NRM_W,
   parameter int DEN_W = ppls_pkg::LEN_W,
   parameter int PAY_W = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [LANES-1:0][MAG_W-1:0]       in_mag,
   input  logic [DEN_W-1:0]                  in_den,
   input  logic [PAY_W-1:0]                  in_pay,
   output logic                              out_valid,
   output logic [LANES-1:0][ppls_pkg::QUO_W-1:0] out_quo,
   output logic [PAY_W-1:0]                  out_pay
);
   localparam int Q_W = ppls_pkg::QUO_W;
   localparam int NUM_W = MAG_W + ppls_pkg::FRAC_W;
   localparam int REM_W = DEN_W + 1;

   logic                        v_ff   [Q_W];
   logic [LANES-1:0][REM_W-1:0] rem_ff [Q_W];
   logic [LANES-1:0][Q_W-1:0]   nb_ff  [Q_W];
   logic [LANES-1:0][Q_W-1:0]   quo_ff [Q_W];
   logic [DEN_W-1:0]            den_ff [Q_W];
   logic [PAY_W-1:0]            pay_ff [Q_W];

   genvar k;
   generate
      for (k = 0; k < Q_W; k++) begin : g_step
         logic                        v_src;
         logic [LANES-1:0][REM_W-1:0] rem_src;
         logic [LANES-1:0][Q_W-1:0]   nb_src;
         logic [LANES-1:0][Q_W-1:0]   quo_src;
         logic [DEN_W-1:0]            den_src;
         logic [PAY_W-1:0]            pay_src;
         logic [LANES-1:0][REM_W-1:0] rem_in;
         logic [LANES-1:0][Q_W-1:0]   quo_in;
         logic [REM_W-1:0]            rem_sh;
         logic                        ge;

         if (k == 0) begin : g_first
            logic [LANES-1:0][NUM_W-1:0] num;
            always_comb begin
               for (int i = 0; i < LANES; i++) begin
                  num[i] = {in_mag[i], {ppls_pkg::FRAC_W{1'b0}}};
                  rem_src[i] = REM_W'(num[i][NUM_W-1:Q_W]);
                  nb_src[i] = num[i][Q_W-1:0];
               end
            end
            assign v_src = in_valid;
            assign quo_src = '0;
            assign den_src = in_den;
            assign pay_src = in_pay;
         end else begin : g_next
            assign v_src = v_ff[k-1];
            assign rem_src = rem_ff[k-1];
            assign nb_src = nb_ff[k-1];
            assign quo_src = quo_ff[k-1];
            assign den_src = den_ff[k-1];
            assign pay_src = pay_ff[k-1];
         end

         always_comb begin
            for (int i = 0; i < LANES; i++) begin
               rem_sh = {rem_src[i][DEN_W-1:0], nb_src[i][Q_W-1]};
               ge = (rem_sh >= {1'b0, den_src});
               rem_in[i] = ge ? (rem_sh - {1'b0, den_src}) : rem_sh;
               quo_in[i] = {quo_src[i][Q_W-2:0], ge};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en) begin
               v_ff[k] <= v_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               nb_ff[k] <= nb_src << 1;
               quo_ff[k] <= quo_in;
               den_ff[k] <= den_src;
               pay_ff[k] <= pay_src;
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[Q_W-1];
   assign out_quo = quo_ff[Q_W-1];
   assign out_pay = pay_ff[Q_W-1];

endmodule

// ----- verif/tb_phong_point_light_shader_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phong point-light shader testbench
// Drives surface hits into the shader, predicts each shaded colour and lit
// flag from its own fixed-point Phong calculation and compares the results
// in order, across several light positions and intensities.
// ----------------------------------------------------------------------------
module tb_phong_point_light_shader_top;

   // The write to this index must be ignored by the shader.
   localparam logic [ppls_pkg::CSR_AW-1:0] REG_SPARE = 3'd6;
   // Generous settle time after the last result, well above the shader latency.
   localparam int DRAIN_CYCLES = 120;

   // One surface hit as the testbench sees it; index 0 is x.
   typedef struct packed {
      logic [7:0]        shin;
      logic [47:0]       coef;     // ambient 47:32, diffuse 31:16, specular 15:0
      logic [47:0]       rgb;      // red 47:32, green 31:16, blue 15:0
      logic [2:0][15:0]  nrm;
      logic [2:0][15:0]  eye;
      logic [2:0][31:0]  pt;
   } hit_type;

   // Shaded result: index 0 is red, matching the result bus layout.
   typedef struct packed {
      logic              lit;
      logic [2:0][15:0]  rgb;
   } result_type;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [ppls_pkg::REQ_W-1:0]    req_tdata;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [ppls_pkg::RSP_W-1:0]    rsp_tdata;
   logic                          rsp_tuser;
   logic                          csr_we;
   logic [ppls_pkg::CSR_AW-1:0]   csr_addr;
   logic [ppls_pkg::CSR_DW-1:0]   csr_wdata;

   // The testbench's own copy of the light registers.
   logic [2:0][31:0]    light_pos;
   logic [2:0][15:0]    light_int;

   hit_type    hit_queue[$];     // requests waiting to be offered
   result_type shade_due[$];     // predicted results not yet returned
   int     req_gap;
   int     rsp_gap;
   bit     idling_on;
   bit     rsp_hold;
   int     n_errors;
   int     n_requests;
   int     n_results;
   int     n_lit;

   phong_point_light_shader_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Q2.14 product, floored and saturated to 32 bits.
   function automatic logic [31:0] q14_mul(logic [31:0] a, logic [31:0] b);
      logic [63:0] p;
      p = (64'(a) * 64'(b)) >> 14;
      return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Square-and-multiply power over the eight exponent bits, starting at 1.0.
   function automatic logic [31:0] q14_pow(logic [31:0] base, logic [7:0] ex);
      logic [31:0] acc;
      acc = 32'd16384;
      for (int i = 0; i < 8; i++) begin
         if (ex[i]) acc = q14_mul(acc, base);
         base = q14_mul(base, base);
      end
      return acc;
   endfunction

   function automatic result_type predict_shade(hit_type h);
      longint      dlt;
      logic [63:0] mag[3];
      logic        neg[3];
      logic [63:0] top, sum, len, q, tot, b;
      longint      lvec[3];
      longint      ln, re, r;
      logic [31:0] ln14, pw, dr, sr, eff, matc, ka, kd, ks;
      result_type  s;
      top = 0;
      sum = 0;
      ln = 0;
      re = 0;
      pw = 0;
      for (int i = 0; i < 3; i++) begin
         dlt = longint'($signed(light_pos[i])) - longint'($signed(h.pt[i]));
         neg[i] = dlt < 0;
         mag[i] = neg[i] ? 64'(-dlt) : 64'(dlt);
         if (mag[i] > top) top = mag[i];
      end
      // Scale the difference so its largest magnitude has its top bit at 29.
      while (top >= (64'd1 << 30)) begin
         top >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (top != 0 && top < (64'd1 << 29)) begin
         top <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
      len = root_floor(sum);
      for (int i = 0; i < 3; i++) begin
         q = (len != 0) ? (mag[i] << 14) / len : 64'd0;
         lvec[i] = neg[i] ? -longint'(q) : longint'(q);
         ln += lvec[i] * longint'($signed(h.nrm[i]));
      end
      ka = 32'(h.coef[47:32]);
      kd = 32'(h.coef[31:16]);
      ks = 32'(h.coef[15:0]);
      s.lit = (ln >= 0);
      ln14 = s.lit ? 32'(ln >>> 14) : 32'd0;
      if (s.lit) begin
         for (int i = 0; i < 3; i++) begin
            r = ((2 * longint'(ln14) * longint'($signed(h.nrm[i]))) >>> 14) - lvec[i];
            re += r * longint'($signed(h.eye[i]));
         end
         if (re >= 0) begin
            b = 64'(re >>> 14);
            pw = q14_pow((b > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : b[31:0], h.shin);
         end
      end
      dr = q14_mul(kd, ln14);
      sr = q14_mul(ks, pw);
      for (int i = 0; i < 3; i++) begin
         matc = 32'((h.rgb >> (32 - 16 * i)) & 48'hFFFF);
         eff = q14_mul(matc, 32'(light_int[i]));
         tot = 64'(q14_mul(eff, ka));
         if (s.lit) tot += 64'(q14_mul(eff, dr)) + 64'(q14_mul(32'(light_int[i]), sr));
         s.rgb[i] = (tot > 64'hFFFF) ? 16'hFFFF : tot[15:0];
      end
      return s;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (!idling_on || p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic logic [15:0] near_unit(bit major);
      logic [15:0] v;
      v = major ? 16'($urandom_range(12000, 16384)) : 16'($urandom_range(0, 6000));
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   // A scene-like hit: nearby point, roughly unit vectors, modest colours.
   // A fifth of the hits are raw noise over the full field ranges.
   function automatic hit_type make_hit();
      hit_type h;
      int      ax;
      if ($urandom_range(0, 4) == 0) begin
         h = hit_type'(ppls_pkg::REQ_W'({$urandom(), $urandom(), $urandom(), $urandom(),
                                         $urandom(), $urandom(), $urandom(), $urandom(),
                                         $urandom(), $urandom()}));
         return h;
      end
      for (int i = 0; i < 3; i++) h.pt[i] = 32'($signed(32'($urandom_range(0, 1 << 22)))
                                              - (1 << 21));
      ax = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) h.nrm[i] = near_unit(i == ax);
      ax = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) h.eye[i] = near_unit(i == ax);
      h.rgb = {16'($urandom_range(0, 16384)), 16'($urandom_range(0, 16384)),
               16'($urandom_range(0, 16384))};
      h.coef = {16'($urandom_range(0, 6000)), 16'($urandom_range(0, 16384)),
                16'($urandom_range(0, 16384))};
      h.shin = 8'($urandom_range(1, 64));
      return h;
   endfunction

   // Light register write; the testbench copy is updated alongside.
   task automatic write_reg(logic [ppls_pkg::CSR_AW-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      if (idx <= ppls_pkg::REG_LIGHT_POS_Z) light_pos[idx] = val;
      else if (idx <= ppls_pkg::REG_LIGHT_BLUE)
         light_int[idx - ppls_pkg::REG_LIGHT_RED] = val[15:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_light(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [15:0] red, logic [15:0] green, logic [15:0] blue);
      write_reg(ppls_pkg::REG_LIGHT_POS_X, x);
      write_reg(ppls_pkg::REG_LIGHT_POS_Y, y);
      write_reg(ppls_pkg::REG_LIGHT_POS_Z, z);
      write_reg(ppls_pkg::REG_LIGHT_RED, 32'(red));
      write_reg(ppls_pkg::REG_LIGHT_GREEN, 32'(green));
      write_reg(ppls_pkg::REG_LIGHT_BLUE, 32'(blue));
   endtask

   // Waits until nothing has been pending for a whole settle period, so the
   // pipeline is empty before the registers may be touched.
   task automatic wait_idle();
      int quiet;
      quiet = 0;
      while (quiet < DRAIN_CYCLES) begin
         @(posedge clock);
         if (hit_queue.size() != 0 || req_tvalid || shade_due.size() != 0) quiet = 0;
         else quiet++;
      end
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) hit_queue.push_back(make_hit());
   endtask

   task automatic add_directed();
      hit_type h;
      // A plain hit, normal and eye along -z, used as the base for the others.
      h = '0;
      h.pt = {32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000};
      h.nrm = {16'hC000, 16'd0, 16'd0};
      h.eye = {16'hC000, 16'd0, 16'd0};
      h.rgb = {16'd16384, 16'd8192, 16'd4096};
      h.coef = {16'd1638, 16'd12000, 16'd8000};
      h.shin = 8'd16;
      hit_queue.push_back(h);
      // Light sitting exactly on the hit point.
      h.pt = light_pos;
      hit_queue.push_back(h);
      // Shininess of zero makes the power exactly one.
      h.pt = {32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000};
      h.shin = 8'd0;
      hit_queue.push_back(h);
      h.shin = 8'd255;
      hit_queue.push_back(h);
      // Normal flipped to +z: ambient alone wherever the light is on the -z side of the hit.
      h.nrm = {16'd16384, 16'd0, 16'd0};
      hit_queue.push_back(h);
      // Eye on the far side, so the reflection misses it.
      h.nrm = {16'hC000, 16'd0, 16'd0};
      h.eye = {16'd16384, 16'd0, 16'd0};
      hit_queue.push_back(h);
      // Saturating colours and coefficients.
      h.eye = {16'hC000, 16'd0, 16'd0};
      h.rgb = '1;
      h.coef = '1;
      hit_queue.push_back(h);
      h.coef = '0;
      hit_queue.push_back(h);
      // Oversized vectors.
      h.coef = {16'd4000, 16'd16384, 16'd16384};
      h.nrm = {16'h8000, 16'h8000, 16'h8000};
      h.eye = {16'h8000, 16'h8000, 16'h8000};
      hit_queue.push_back(h);
      h.nrm = {16'h7FFF, 16'h7FFF, 16'h7FFF};
      h.eye = {16'h7FFF, 16'h7FFF, 16'h7FFF};
      hit_queue.push_back(h);
      // Extreme points.
      h.pt = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      hit_queue.push_back(h);
      h.pt = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      hit_queue.push_back(h);
      h.pt = {32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001};
      hit_queue.push_back(h);
      // Everything at its highest and at its lowest.
      hit_queue.push_back('1);
      hit_queue.push_back('0);
   endtask

   // Request driver: a new request is offered only once the previous one is
   // taken, so valid never drops with data pending.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            shade_due.push_back(predict_shade(hit_type'(req_tdata)));
            n_requests++;
         end
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (hit_queue.size() != 0) begin
            req_tdata <= hit_queue.pop_front();
            req_tvalid <= 1'b1;
            req_gap <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor and receiver stalls.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.rgb = rsp_tdata;
            got.lit = rsp_tuser;
            n_results++;
            if (got.lit) n_lit++;
            if (shade_due.size() == 0) begin
               n_errors++;
               $display("%0t: unexpected result rgb=%h lit=%b", $time, got.rgb, got.lit);
            end else begin
               want = shade_due.pop_front();
               for (int i = 0; i < 3; i++) begin
                  if (got.rgb[i] !== want.rgb[i]) begin
                     n_errors++;
                     $display("%0t: channel %0d expected %h actual %h",
                              $time, i, want.rgb[i], got.rgb[i]);
                  end
               end
               if (got.lit !== want.lit) begin
                  n_errors++;
                  $display("%0t: lit expected %b actual %b", $time, want.lit, got.lit);
               end
            end
         end
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_gap <= pick_gap();
         end
      end
   end

   // Main sequence: reset, then phases of requests with the light changed
   // between them while the shader is empty.
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      rsp_hold = 1'b0;
      idling_on = 1'b0;
      n_errors = 0;
      n_requests = 0;
      n_results = 0;
      n_lit = 0;
      light_pos = '0;
      light_int = {3{ppls_pkg::INT_RESET}};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset light values, back to back with no idling.
      add_directed();
      run_random(80);
      wait_idle();

      idling_on = 1'b1;
      set_light(32'h0005_0000, 32'h0003_0000, 32'hFFFB_0000, 16'd16384, 16'd12000, 16'd8000);
      write_reg(REG_SPARE, 32'hFFFF_FFFF);
      add_directed();
      run_random(120);
      wait_idle();

      // Farthest light and brightest intensities; the receiver stalls for a
      // long stretch here so the pipeline fills and holds off requests.
      set_light(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random(120);
      repeat (20) @(posedge clock);
      rsp_hold = 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold = 1'b0;
      wait_idle();

      set_light(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'd0, 16'd0);
      run_random(100);
      wait_idle();

      idling_on = 1'b0;
      set_light(32'h0000_8000, 32'h0010_0000, 32'h0002_0000, 16'd20000, 16'd16384, 16'd300);
      run_random(60);
      wait_idle();
      idling_on = 1'b1;
      run_random(100);
      wait_idle();

      $display("Shaded %0d hits (%0d lit) over five light settings, with idling, stalls",
               n_results, n_lit);
      $display("and one long receiver hold-off.");
      if (n_errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
